### rtl/cspf_pkg.sv
// Shared types and constants for the call stack function profiler.
// Used by every module of the block but cspf_div; depends on nothing.
package cspf_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int STACK_DEPTH_DEF   = 32;

  // Input action codes
  localparam logic [1:0] ACT_ENTER = 2'd0;
  localparam logic [1:0] ACT_EXIT  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_REC  = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_UPDATED  = 3'd5;

  localparam logic [5:0] DEPTH_MAX = 6'd63;

  // Event class decided by the front end
  typedef enum logic [2:0] {
    K_NOP, K_NOREC, K_READ, K_ENTER, K_EXIT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  idx;
    logic [31:0] ts;
  } item_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic [31:0] start;
    logic [31:0] child;
  } frame_t;

  typedef struct packed {
    logic [31:0] count;
    logic [47:0] total;
    logic [47:0] excl;
    logic [31:0] min;
    logic [31:0] max;
    logic [5:0]  depth;
  } entry_t;

endpackage

### rtl/cspf_front.sv
// Front end: holds the recording register and classifies incoming events.
// Depends on cspf_pkg.
module cspf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [7:0]       idx,
  input  logic [31:0]      ts,
  input  logic             clearing,
  output logic             q_valid,
  input  logic             q_ready,
  output cspf_pkg::item_t  q_item
);

  logic recording;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      recording <= 1'b0;
    end else if (cfg_valid) begin
      recording <= cfg_data;
    end
  end

  // Classify: reads and unused codes bypass the recording check
  always_comb begin
    q_item.idx = idx;
    q_item.ts  = ts;
    case (action)
      cspf_pkg::ACT_READ:  q_item.kind = cspf_pkg::K_READ;
      cspf_pkg::ACT_ENTER: q_item.kind = recording ? cspf_pkg::K_ENTER : cspf_pkg::K_NOREC;
      cspf_pkg::ACT_EXIT:  q_item.kind = recording ? cspf_pkg::K_EXIT : cspf_pkg::K_NOREC;
      default:             q_item.kind = cspf_pkg::K_NOP;
    endcase
  end

  assign q_valid  = in_valid && !clearing;
  assign in_ready = q_ready && !clearing;

endmodule

### rtl/cspf_queue.sv
// Two-entry queue between front and back end.
// Depends on cspf_pkg.
module cspf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  cspf_pkg::item_t  wr_item,
  output logic             rd_valid,
  input  logic             rd_ready,
  output cspf_pkg::item_t  rd_item
);

  cspf_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;
  logic            pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/cspf_div.sv
// Radix-2 restoring divider: 48-bit total by 32-bit count, quotient saturated to 32 bits.
// A zero divisor gives zero. Depends on nothing but its ports.
module cspf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [47:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh   = {rem, quo[47]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = (quo[47:32] != 16'd0) ? 32'hFFFF_FFFF : quo[31:0];

  // One quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= (divisor == 32'd0) ? 48'd0 : dividend;
        dvs  <= divisor;
        rem  <= 32'd0;
        cnt  <= 6'd0;
        busy <= (divisor != 32'd0);
        done <= (divisor == 32'd0);
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/cspf_back.sv
// Back end: frame stack, profile table with read-modify-write, average divider, result register.
// Depends on cspf_pkg and cspf_div.
module cspf_back #(
  parameter int TABLE_ENTRIES = cspf_pkg::TABLE_ENTRIES_DEF,
  parameter int STACK_DEPTH   = cspf_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  cspf_pkg::item_t     q_item,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output cspf_pkg::entry_t    out_entry,
  output logic [31:0]         out_avg
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_STK, S_UPD, S_TRD, S_DIV, S_OUT
  } state_t;

  state_t            state;
  logic [LW-1:0]     level;
  cspf_pkg::item_t   cur;
  logic [31:0]       dur;
  logic [31:0]       excl;
  logic [5:0]        depth;
  logic [AW-1:0]     clr_addr;

  cspf_pkg::frame_t  stk_mem [STACK_DEPTH];
  cspf_pkg::frame_t  stk_rd;
  cspf_pkg::entry_t  tbl_mem [TABLE_ENTRIES];
  cspf_pkg::entry_t  tbl_rd;

  logic              stk_we;
  logic [SW-1:0]     stk_wa;
  cspf_pkg::frame_t  stk_wd;
  logic              stk_re;
  logic [SW-1:0]     stk_ra;
  logic              tbl_we;
  logic [AW-1:0]     tbl_wa;
  cspf_pkg::entry_t  tbl_wd;
  logic              tbl_re;
  logic [AW-1:0]     tbl_ra;

  logic              q_in_range;
  logic              cur_in_range;
  logic [31:0]       top_dur;
  logic [LW:0]       depth_full;
  logic [32:0]       child_sum;
  logic [48:0]       tot_sum;
  logic [48:0]       exc_sum;
  cspf_pkg::entry_t  nent;
  logic              div_start;
  logic [47:0]       div_dvd;
  logic [31:0]       div_dvs;
  logic              div_done;
  logic [31:0]       div_q;

  assign q_in_range   = (32'(q_item.idx) < 32'(TABLE_ENTRIES));
  assign cur_in_range = (32'(cur.idx) < 32'(TABLE_ENTRIES));
  assign q_ready      = (state == S_IDLE);
  assign clearing     = (state == S_CLEAR);

  // Duration and depth of the popped frame
  assign top_dur    = cur.ts - stk_rd.start;
  assign depth_full = (LW + 1)'(level) + (LW + 1)'(1);

  // Parent credit and table update arithmetic
  assign child_sum = {1'b0, stk_rd.child} + {1'b0, dur};
  assign tot_sum   = {1'b0, tbl_rd.total} + 49'(dur);
  assign exc_sum   = {1'b0, tbl_rd.excl} + 49'(excl);

  always_comb begin
    nent.count = (tbl_rd.count == 32'hFFFF_FFFF) ? tbl_rd.count : tbl_rd.count + 32'd1;
    nent.total = tot_sum[48] ? 48'hFFFF_FFFF_FFFF : tot_sum[47:0];
    nent.excl  = exc_sum[48] ? 48'hFFFF_FFFF_FFFF : exc_sum[47:0];
    nent.min   = (tbl_rd.min == 32'd0 || dur < tbl_rd.min) ? dur : tbl_rd.min;
    nent.max   = (dur > tbl_rd.max) ? dur : tbl_rd.max;
    nent.depth = (depth > tbl_rd.depth) ? depth : tbl_rd.depth;
  end

  // Memory port control
  always_comb begin
    stk_we = 1'b0;
    stk_wa = SW'(level);
    stk_wd = '{idx: q_item.idx, start: q_item.ts, child: 32'd0};
    stk_re = 1'b0;
    stk_ra = SW'(level - LW'(1));
    tbl_we = 1'b0;
    tbl_wa = clr_addr;
    tbl_wd = '0;
    tbl_re = 1'b0;
    tbl_ra = AW'(q_item.idx);
    unique case (state)
      S_CLEAR: tbl_we = 1'b1;
      S_IDLE: begin
        if (q_valid) begin
          stk_we = (q_item.kind == cspf_pkg::K_ENTER) && (32'(level) < 32'(STACK_DEPTH));
          stk_re = (q_item.kind == cspf_pkg::K_EXIT) && (level != '0);
          tbl_re = (q_item.kind == cspf_pkg::K_READ) && q_in_range;
        end
      end
      S_STK: begin
        stk_re = (level != '0);
        tbl_re = cur_in_range;
        tbl_ra = AW'(cur.idx);
      end
      S_UPD: begin
        stk_we = (level != '0);
        stk_wa = SW'(level - LW'(1));
        stk_wd = '{idx: stk_rd.idx, start: stk_rd.start,
                   child: child_sum[32] ? 32'hFFFF_FFFF : child_sum[31:0]};
        tbl_we = cur_in_range;
        tbl_wa = AW'(cur.idx);
        tbl_wd = nent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (tbl_re) tbl_rd <= tbl_mem[tbl_ra];
  end

  // Average: started with the updated entry or the entry just read
  assign div_start = ((state == S_UPD) && cur_in_range) || (state == S_TRD);
  assign div_dvd   = (state == S_UPD) ? nent.total : tbl_rd.total;
  assign div_dvs   = (state == S_UPD) ? nent.count : tbl_rd.count;

  cspf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer with result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      level     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == 32'(TABLE_ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_item;
            out_entry  <= '0;
            out_avg    <= 32'd0;
            out_status <= cspf_pkg::ST_OK;
            state      <= S_OUT;
            out_valid  <= 1'b1;
            case (q_item.kind)
              cspf_pkg::K_NOREC: out_status <= cspf_pkg::ST_NOT_REC;
              cspf_pkg::K_READ: begin
                if (q_in_range) begin
                  state     <= S_TRD;
                  out_valid <= 1'b0;
                end
              end
              cspf_pkg::K_ENTER: begin
                if (32'(level) < 32'(STACK_DEPTH)) level <= level + LW'(1);
                else out_status <= cspf_pkg::ST_FULL;
              end
              cspf_pkg::K_EXIT: begin
                if (level == '0) begin
                  out_status <= cspf_pkg::ST_EMPTY;
                end else begin
                  level     <= level - LW'(1);
                  state     <= S_STK;
                  out_valid <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_STK: begin
          dur   <= top_dur;
          excl  <= (top_dur > stk_rd.child) ? top_dur - stk_rd.child : 32'd0;
          depth <= (32'(depth_full) > 32'(cspf_pkg::DEPTH_MAX)) ?
                   cspf_pkg::DEPTH_MAX : 6'(depth_full);
          if (stk_rd.idx != cur.idx) begin
            out_status <= cspf_pkg::ST_MISMATCH;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (cur_in_range) begin
            out_entry  <= nent;
            out_status <= cspf_pkg::ST_UPDATED;
            state      <= S_DIV;
          end else begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_TRD: begin
          out_entry <= tbl_rd;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_avg   <= div_q;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    32'(level) <= 32'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_upd_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == cspf_pkg::ST_UPDATED |-> out_entry.count != 32'd0)
    else $error("updated entry with zero count");

  a_norec_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == cspf_pkg::ST_NOT_REC |-> out_entry == '0 && out_avg == 32'd0)
    else $error("not-recording result carries data");

  a_enter_level: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && q_valid && q_item.kind == cspf_pkg::K_ENTER &&
    32'(level) < 32'(STACK_DEPTH) |=> level == $past(level) + LW'(1))
    else $error("enter did not push");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_ready)
    else $error("queue popped during clear");
`endif

endmodule

### rtl/call_stack_function_profiler.sv
// Top level of the call stack function profiler: front end, queue, back end.
// Depends on cspf_pkg, cspf_front, cspf_queue, cspf_back.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tuser action, tdata index + timestamp
//   m_*       out  m_tvalid/m_tready  tuser status, tdata entry fields + average
//   cfg_*     in   cfg_valid/cfg_ready cfg_data recording enable
//
// Enter, not-recording, empty, full, unused and out-of-range read events go straight to S_OUT;
// a mismatch passes S_STK; reads and in-range matching exits go through the 48-step divider.
// After reset the table is zeroed one entry a cycle, no events taken.
// A two-entry queue keeps input accepted while a result waits on m_tready.
module call_stack_function_profiler #(
  parameter int TABLE_ENTRIES = cspf_pkg::TABLE_ENTRIES_DEF,
  parameter int STACK_DEPTH   = cspf_pkg::STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,   // action
  input  logic [39:0]  s_tdata,   // function_index, timestamp
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [2:0]   m_tuser,   // status
  output logic [231:0] m_tdata,   // completed calls, total_cycles, exclusive_cycles, min_cycles,
                                  // max_cycles, average_cycles, deepest_level, zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);

  logic             fq_valid;
  logic             fq_ready;
  cspf_pkg::item_t  fq_item;
  logic             qb_valid;
  logic             qb_ready;
  cspf_pkg::item_t  qb_item;
  logic             clearing;
  cspf_pkg::entry_t ent;
  logic [31:0]      avg;

  cspf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .action    (s_tuser),
    .idx       (s_tdata[7:0]),
    .ts        (s_tdata[39:8]),
    .clearing  (clearing),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  cspf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  cspf_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_item     (qb_item),
    .clearing   (clearing),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_entry  (ent),
    .out_avg    (avg)
  );

  // Pack result fields, lowest first
  assign m_tdata = {2'b00, ent.depth, avg, ent.max, ent.min, ent.excl, ent.total, ent.count};

endmodule
